// ===== hw/rtl/lcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcf_pkg: shared definitions for the LED strip colour fader
// Sizes, fixed-point formats, operation and status codes, the LED record
// carried along the cell ring, and the colour palette.
// ----------------------------------------------------------------------------
package lcf_pkg;

  localparam int LED_COUNT = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = FRAC_BITS + 10;
  localparam int STEP_W    = FRAC_BITS + 9;
  localparam int QUO_W     = STEP_W - 1;
  localparam int DEN_W     = 9;
  localparam int PAL_SIZE  = 47;

  localparam logic [1:0] OP_SET_RAW = 2'd0;
  localparam logic [1:0] OP_SET_PAL = 2'd1;
  localparam logic [1:0] OP_ALL_PAL = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [1:0] ST_FADING = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_ABORT  = 2'd2;

  typedef struct packed {
    logic [23:0]              cur;   // R 23:16, G 15:8, B 7:0
    logic [23:0]              tgt;
    logic signed [ACC_W-1:0]  acc_r;
    logic signed [ACC_W-1:0]  acc_g;
    logic signed [ACC_W-1:0]  acc_b;
    logic signed [STEP_W-1:0] stp_r;
    logic signed [STEP_W-1:0] stp_g;
    logic signed [STEP_W-1:0] stp_b;
  } rec_t;

  function automatic logic [23:0] palette(input logic [5:0] ci);
    logic [23:0] c;
    unique case (ci)
      6'd0:  c = {8'd255, 8'd0,   8'd0};
      6'd1:  c = {8'd255, 8'd165, 8'd0};
      6'd2:  c = {8'd255, 8'd255, 8'd0};
      6'd3:  c = {8'd0,   8'd255, 8'd0};
      6'd4:  c = {8'd0,   8'd255, 8'd127};
      6'd5:  c = {8'd0,   8'd0,   8'd255};
      6'd6:  c = {8'd138, 8'd43,  8'd226};
      6'd7:  c = {8'd255, 8'd255, 8'd255};
      6'd8:  c = {8'd0,   8'd0,   8'd0};
      6'd9:  c = {8'd255, 8'd255, 8'd240};
      6'd10: c = {8'd255, 8'd182, 8'd193};
      6'd11: c = {8'd255, 8'd69,  8'd0};
      6'd12: c = {8'd128, 8'd0,   8'd0};
      6'd13: c = {8'd255, 8'd140, 8'd0};
      6'd14: c = {8'd255, 8'd215, 8'd0};
      6'd15: c = {8'd173, 8'd255, 8'd47};
      6'd16: c = {8'd0,   8'd128, 8'd0};
      6'd17: c = {8'd75,  8'd0,   8'd130};
      6'd18: c = {8'd255, 8'd105, 8'd180};
      6'd19: c = {8'd255, 8'd20,  8'd147};
      6'd20: c = {8'd255, 8'd160, 8'd122};
      6'd21: c = {8'd30,  8'd144, 8'd255};
      6'd22: c = {8'd255, 8'd228, 8'd196};
      6'd23: c = {8'd255, 8'd218, 8'd185};
      6'd24: c = {8'd240, 8'd230, 8'd140};
      6'd25: c = {8'd255, 8'd239, 8'd213};
      6'd26: c = {8'd255, 8'd245, 8'd238};
      6'd27: c = {8'd210, 8'd180, 8'd140};
      6'd28: c = {8'd255, 8'd228, 8'd196};
      6'd29: c = {8'd173, 8'd216, 8'd230};
      6'd30: c = {8'd240, 8'd128, 8'd128};
      6'd31: c = {8'd255, 8'd192, 8'd203};
      6'd32: c = {8'd255, 8'd182, 8'd193};
      6'd33: c = {8'd255, 8'd160, 8'd122};
      6'd34: c = {8'd210, 8'd105, 8'd30};
      6'd35: c = {8'd255, 8'd165, 8'd0};
      6'd36: c = {8'd255, 8'd127, 8'd39};
      6'd37: c = {8'd255, 8'd69,  8'd0};
      6'd38: c = {8'd255, 8'd99,  8'd71};
      6'd39: c = {8'd255, 8'd111, 8'd207};
      6'd40: c = {8'd255, 8'd20,  8'd147};
      6'd41: c = {8'd0,   8'd100, 8'd0};
      6'd42: c = {8'd72,  8'd61,  8'd139};
      6'd43: c = {8'd106, 8'd90,  8'd205};
      6'd44: c = {8'd255, 8'd140, 8'd104};
      6'd45: c = {8'd255, 8'd160, 8'd122};
      6'd46: c = {8'd255, 8'd218, 8'd185};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/led_strip_color_fader_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Target-setting words are taken while idle and give no result. A tick
// during a fade walks the ring, held by output stalls; a tick that starts a
// fade scans the ring, runs three dividers side by side for each LED in use
// and walks again; a tick with nothing to fade scans and sends the idle word.
// Words are taken one at a time: in_stall stays high until a tick is done.
// Reset: synchronous, clears every LED record, the fade count and out_valid.
// ----------------------------------------------------------------------------
// led_strip_color_fader_top: linear RGB fader for a strip of up to 16 LEDs
// A ring of LED cells rotates past one processing head that finds the fade
// length, computes per-channel steps and advances the accumulators.
// ----------------------------------------------------------------------------
module led_strip_color_fader_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [4:0]  cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  led_index,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [5:0]  color_index,
  input  wire logic        abort_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_led,
  output logic [23:0]      grb_word,
  output logic [1:0]       status,
  output logic             frame_valid,
  output logic             last
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV_START, S_DIV_WAIT, S_TICK, S_IDLE_OUT}
    state_t;

  state_t        state;
  logic [4:0]    leds_in_use;
  logic [4:0]    n_eff;
  logic [3:0]    pos;
  logic [7:0]    steps_left;
  logic          abort_q;
  logic [1:0]    tick_status;
  logic          shift;
  lcf_pkg::rec_t rec [lcf_pkg::LED_COUNT];
  lcf_pkg::rec_t head_out;
  lcf_pkg::rec_t head;
  logic          in_accept;
  logic          slot_free;
  logic          pos_active;
  logic          pos_end;

  assign in_stall  = state != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign head      = rec[0];
  assign pos_active = {1'b0, pos} < n_eff;
  assign pos_end    = pos == 4'(lcf_pkg::LED_COUNT - 1);

  // Zero is treated as one LED and anything above the strip as the strip.
  always_comb begin
    if (leds_in_use == 5'd0) n_eff = 5'd1;
    else if (leds_in_use > 5'(lcf_pkg::LED_COUNT)) n_eff = 5'(lcf_pkg::LED_COUNT);
    else n_eff = leds_in_use;
  end

  always_ff @(posedge clk) begin
    if (rst) leds_in_use <= 5'd16;
    else if (cfg_write_enable) leds_in_use <= cfg_write_data;
  end

  // Target writes go straight to the cell of that LED: the ring only rests
  // at its home alignment, so cell i always holds LED i while idle.
  logic [23:0] wr_color;
  logic        wr_pal_ok;
  assign wr_pal_ok = color_index < 6'(lcf_pkg::PAL_SIZE);
  assign wr_color  = (op == lcf_pkg::OP_SET_RAW) ? {red, green, blue}
                                                 : lcf_pkg::palette(color_index);

  for (genvar i = 0; i < lcf_pkg::LED_COUNT; i++) begin : g_ring
    logic we;
    assign we = in_accept && (
                  (op == lcf_pkg::OP_SET_RAW && led_index == 4'(i)) ||
                  (op == lcf_pkg::OP_SET_PAL && wr_pal_ok && led_index == 4'(i)) ||
                  (op == lcf_pkg::OP_ALL_PAL && wr_pal_ok));
    if (i == lcf_pkg::LED_COUNT - 1) begin : g_tail
      lcf_cell u_cell (.clk, .rst, .shift, .rec_in(head_out), .tgt_we(we),
                       .tgt_in(wr_color), .rec(rec[i]));
    end else begin : g_body
      lcf_cell u_cell (.clk, .rst, .shift, .rec_in(rec[i+1]), .tgt_we(we),
                       .tgt_in(wr_color), .rec(rec[i]));
    end
  end

  // Per-channel differences of the LED at the head.
  logic [7:0] d_r, d_g, d_b, d_max;
  logic       up_r, up_g, up_b;
  assign up_r = head.tgt[23:16] >= head.cur[23:16];
  assign up_g = head.tgt[15:8]  >= head.cur[15:8];
  assign up_b = head.tgt[7:0]   >= head.cur[7:0];
  assign d_r  = up_r ? head.tgt[23:16] - head.cur[23:16] : head.cur[23:16] - head.tgt[23:16];
  assign d_g  = up_g ? head.tgt[15:8]  - head.cur[15:8]  : head.cur[15:8]  - head.tgt[15:8];
  assign d_b  = up_b ? head.tgt[7:0]   - head.cur[7:0]   : head.cur[7:0]   - head.tgt[7:0];
  always_comb begin
    d_max = d_r;
    if (d_g > d_max) d_max = d_g;
    if (d_b > d_max) d_max = d_b;
  end

  // Step = (|diff| << FRAC) / len, rounded half away from zero, which is
  // (2*mag + len) / (2*len) on magnitudes.
  logic [lcf_pkg::ACC_W-1:0] num_r, num_g, num_b;
  logic [lcf_pkg::DEN_W-1:0] den;
  logic [lcf_pkg::QUO_W-1:0] q_r, q_g, q_b;
  logic                      dn_r, dn_g, dn_b, div_start;
  assign den   = {steps_left, 1'b0};
  assign num_r = (lcf_pkg::ACC_W'(d_r) << (lcf_pkg::FRAC_BITS + 1))
                 + lcf_pkg::ACC_W'(steps_left);
  assign num_g = (lcf_pkg::ACC_W'(d_g) << (lcf_pkg::FRAC_BITS + 1))
                 + lcf_pkg::ACC_W'(steps_left);
  assign num_b = (lcf_pkg::ACC_W'(d_b) << (lcf_pkg::FRAC_BITS + 1))
                 + lcf_pkg::ACC_W'(steps_left);
  assign div_start = state == S_DIV_START && pos_active;

  lcf_divider u_div_r (.clk, .rst, .start(div_start), .dividend(num_r), .divisor(den),
                       .quotient(q_r), .done(dn_r));
  lcf_divider u_div_g (.clk, .rst, .start(div_start), .dividend(num_g), .divisor(den),
                       .quotient(q_g), .done(dn_g));
  lcf_divider u_div_b (.clk, .rst, .start(div_start), .dividend(num_b), .divisor(den),
                       .quotient(q_b), .done(dn_b));

  function automatic logic signed [lcf_pkg::STEP_W-1:0] signed_step(
      input logic [lcf_pkg::QUO_W-1:0] q, input logic up);
    logic signed [lcf_pkg::STEP_W-1:0] s;
    s = signed'({1'b0, q});
    return up ? s : -s;
  endfunction

  function automatic logic signed [lcf_pkg::ACC_W-1:0] acc_add(
      input logic signed [lcf_pkg::ACC_W-1:0] a, input logic signed [lcf_pkg::STEP_W-1:0] s);
    logic signed [lcf_pkg::ACC_W:0] v;
    v = (lcf_pkg::ACC_W+1)'(a) + (lcf_pkg::ACC_W+1)'(s);
    if (v[lcf_pkg::ACC_W] != v[lcf_pkg::ACC_W-1])
      return v[lcf_pkg::ACC_W] ? {1'b1, {(lcf_pkg::ACC_W-1){1'b0}}}
                               : {1'b0, {(lcf_pkg::ACC_W-1){1'b1}}};
    return v[lcf_pkg::ACC_W-1:0];
  endfunction

  function automatic logic [7:0] round_clamp(input logic signed [lcf_pkg::ACC_W-1:0] a);
    logic [lcf_pkg::ACC_W-1:0] r;
    r = (lcf_pkg::ACC_W'(a) + (lcf_pkg::ACC_W'(1) << (lcf_pkg::FRAC_BITS - 1)))
        >> lcf_pkg::FRAC_BITS;
    if (a[lcf_pkg::ACC_W-1]) return 8'd0;
    if (r > lcf_pkg::ACC_W'(255)) return 8'd255;
    return r[7:0];
  endfunction

  logic signed [lcf_pkg::ACC_W-1:0] na_r, na_g, na_b;
  logic [7:0] c_r, c_g, c_b;
  assign na_r = acc_add(head.acc_r, head.stp_r);
  assign na_g = acc_add(head.acc_g, head.stp_g);
  assign na_b = acc_add(head.acc_b, head.stp_b);
  assign c_r  = round_clamp(na_r);
  assign c_g  = round_clamp(na_g);
  assign c_b  = round_clamp(na_b);

  // What the head writes back into the tail of the ring.
  always_comb begin
    head_out = head;
    if (state == S_DIV_WAIT) begin
      head_out.acc_r = lcf_pkg::ACC_W'(head.cur[23:16]) << lcf_pkg::FRAC_BITS;
      head_out.acc_g = lcf_pkg::ACC_W'(head.cur[15:8])  << lcf_pkg::FRAC_BITS;
      head_out.acc_b = lcf_pkg::ACC_W'(head.cur[7:0])   << lcf_pkg::FRAC_BITS;
      head_out.stp_r = signed_step(q_r, up_r);
      head_out.stp_g = signed_step(q_g, up_g);
      head_out.stp_b = signed_step(q_b, up_b);
    end else if (state == S_TICK && pos_active) begin
      head_out.acc_r = na_r;
      head_out.acc_g = na_g;
      head_out.acc_b = na_b;
      // On the final frame of a fade every channel snaps to its target.
      head_out.cur   = (tick_status == lcf_pkg::ST_DONE) ? head.tgt : {c_r, c_g, c_b};
    end
  end

  always_comb begin
    unique case (state)
      S_SCAN:      shift = 1'b1;
      S_DIV_START: shift = !pos_active;
      S_DIV_WAIT:  shift = dn_r && dn_g && dn_b;
      S_TICK:      shift = !pos_active || slot_free;
      default:     shift = 1'b0;
    endcase
  end

  // Fade count and status for the frame about to be walked.
  logic [7:0] sl_after;
  logic [1:0] st_after;
  assign sl_after = abort_q ? steps_left : steps_left - 8'd1;
  assign st_after = abort_q ? lcf_pkg::ST_ABORT
                  : (sl_after == 8'd0) ? lcf_pkg::ST_DONE : lcf_pkg::ST_FADING;

  logic [7:0] scan_max;
  assign scan_max = (pos_active && d_max > steps_left) ? d_max : steps_left;

  // A new output word is loaded whenever the walk emits an LED or the idle
  // frame goes out.
  logic out_load;
  assign out_load = (state == S_TICK && shift && pos_active) ||
                    (state == S_IDLE_OUT && slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      steps_left  <= '0;
      abort_q     <= 1'b0;
      tick_status <= lcf_pkg::ST_DONE;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_accept && op == lcf_pkg::OP_TICK) begin
            pos     <= '0;
            abort_q <= abort_request;
            state   <= (steps_left == 8'd0) ? S_SCAN : S_TICK;
            if (steps_left != 8'd0) begin
              steps_left  <= abort_request ? steps_left : steps_left - 8'd1;
              tick_status <= abort_request ? lcf_pkg::ST_ABORT
                           : (steps_left == 8'd1) ? lcf_pkg::ST_DONE : lcf_pkg::ST_FADING;
            end
          end
        end
        S_SCAN: begin
          steps_left <= scan_max;
          pos        <= pos + 4'd1;
          if (pos_end) state <= (scan_max == 8'd0) ? S_IDLE_OUT : S_DIV_START;
        end
        S_DIV_START: begin
          if (pos_active) begin
            state <= S_DIV_WAIT;
          end else begin
            pos <= pos + 4'd1;
            if (pos_end) begin
              state       <= S_TICK;
              steps_left  <= sl_after;
              tick_status <= st_after;
            end
          end
        end
        S_DIV_WAIT: begin
          if (shift) begin
            pos <= pos + 4'd1;
            if (pos_end) begin
              state       <= S_TICK;
              steps_left  <= sl_after;
              tick_status <= st_after;
            end else begin
              state <= S_DIV_START;
            end
          end
        end
        S_TICK: begin
          if (shift) begin
            if (pos_active) begin
              out_led     <= pos;
              grb_word    <= {c_g, c_r, c_b};
              status      <= tick_status;
              frame_valid <= 1'b1;
              last        <= ({1'b0, pos} + 5'd1) == n_eff;
            end
            pos <= pos + 4'd1;
            if (pos_end) state <= S_IDLE;
          end
        end
        S_IDLE_OUT: begin
          if (slot_free) begin
            out_led     <= '0;
            grb_word    <= '0;
            status      <= lcf_pkg::ST_DONE;
            frame_valid <= 1'b0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lcf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcf_cell: one LED record in the ring
// Holds the colour, target, accumulators and steps of one LED and passes the
// record to its neighbour whenever the ring shifts.
// ----------------------------------------------------------------------------
module lcf_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          shift,
  input  wire lcf_pkg::rec_t rec_in,
  input  wire logic          tgt_we,
  input  wire logic [23:0]   tgt_in,
  output lcf_pkg::rec_t      rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (shift) begin
      rec <= rec_in;
    end else if (tgt_we) begin
      rec.tgt <= tgt_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lcf_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcf_divider: restoring divider, one quotient bit per cycle
// Loads its operands on start and pulses done once the last quotient bit is in.
// ----------------------------------------------------------------------------
module lcf_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lcf_pkg::ACC_W-1:0]   dividend,
  input  wire logic [lcf_pkg::DEN_W-1:0]   divisor,
  output logic [lcf_pkg::QUO_W-1:0]        quotient,
  output logic                             done
);

  logic                        busy;
  logic [4:0]                  cnt;
  logic [lcf_pkg::ACC_W-1:0]   num;
  logic [lcf_pkg::DEN_W-1:0]   rem;
  logic [lcf_pkg::DEN_W:0]     trial;
  logic                        fits;

  assign trial = {rem, num[lcf_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        num      <= dividend;
        rem      <= '0;
        quotient <= '0;
      end else if (busy) begin
        rem      <= fits ? lcf_pkg::DEN_W'(trial - {1'b0, divisor})
                         : trial[lcf_pkg::DEN_W-1:0];
        num      <= {num[lcf_pkg::ACC_W-2:0], 1'b0};
        quotient <= {quotient[lcf_pkg::QUO_W-2:0], fits};
        cnt      <= cnt + 5'd1;
        if (cnt == 5'(lcf_pkg::ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lcf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcf_checker: port-level checks for the LED strip colour fader
// Watches the ports of the top level only.
// ----------------------------------------------------------------------------
module lcf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_write_enable,
  input wire logic [4:0]  cfg_write_data,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  op,
  input wire logic [3:0]  led_index,
  input wire logic [7:0]  red,
  input wire logic [7:0]  green,
  input wire logic [7:0]  blue,
  input wire logic [5:0]  color_index,
  input wire logic        abort_request,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  out_led,
  input wire logic [23:0] grb_word,
  input wire logic [1:0]  status,
  input wire logic        frame_valid,
  input wire logic        last
);

  // A held word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(grb_word) && $stable(out_led))
    else $error("stalled output word changed");

  // The idle-tick word is a lone, empty, complete frame.
  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |-> last && grb_word == 24'd0 && out_led == 4'd0 &&
                                  status == lcf_pkg::ST_DONE)
    else $error("malformed idle word");

  // A tick keeps the block busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == lcf_pkg::OP_TICK |=> in_stall)
    else $error("tick accepted without going busy");

  // Target-setting words never produce a result in the next cycle.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op != lcf_pkg::OP_TICK && !out_valid |=> !out_valid)
    else $error("result appeared after a target write");

endmodule

bind led_strip_color_fader_top lcf_checker u_lcf_checker (.*);
`default_nettype wire

// ===== test/led_strip_color_fader_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_color_fader_top_tb: self-checking bench for the LED colour fader
// Drives target-setting, tick and register words with random gaps, predicts every LED
// word of each tick frame and compares it field by field at the output.
// ----------------------------------------------------------------------------
module led_strip_color_fader_top_tb;

  typedef struct {
    logic [1:0] op;
    logic [3:0] led;
    logic [7:0] r, g, b;
    logic [5:0] ci;
    logic       abt;
    logic       is_cfg;   // a register write rather than a word
    logic [4:0] cfg_val;
  } word_t;

  typedef struct {
    logic [3:0]  led;
    logic [23:0] grb;
    logic [1:0]  st;
    logic        fv;
    logic        lst;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic [4:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [3:0] led_index = '0;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic [5:0] color_index = '0;
  logic abort_request = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_led;
  logic [23:0] grb_word;
  logic [1:0] status;
  logic frame_valid, last;

  // The clock runs at 100 MHz.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_strip_color_fader_top u_top (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .led_index(led_index), .red(red), .green(green), .blue(blue),
    .color_index(color_index), .abort_request(abort_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_led(out_led), .grb_word(grb_word), .status(status),
    .frame_valid(frame_valid), .last(last)
  );

  // Predictor state: a private copy of every LED and of the fade count.
  logic [23:0] mdl_cur [lcf_pkg::LED_COUNT];
  logic [23:0] mdl_tgt [lcf_pkg::LED_COUNT];
  longint      mdl_acc [lcf_pkg::LED_COUNT][3];
  longint      mdl_stp [lcf_pkg::LED_COUNT][3];
  int          mdl_left;
  int          mdl_leds;

  word_t  pending_words[$];
  frame_t expected_frames[$];
  int     fail_count = 0;
  bit     stim_done = 1'b0;
  bit     hold_off = 1'b0;
  bit     quiet = 1'b0;      // a stretch where neither side idles
  int     idle_cycles = 0;

  // The palette is written out here independently of the package.
  function automatic logic [23:0] pal_rgb(input int ci);
    logic [23:0] t [lcf_pkg::PAL_SIZE];
    t = '{24'hFF0000, 24'hFFA500, 24'hFFFF00, 24'h00FF00, 24'h00FF7F,
          24'h0000FF, 24'h8A2BE2, 24'hFFFFFF, 24'h000000, 24'hFFFFF0,
          24'hFFB6C1, 24'hFF4500, 24'h800000, 24'hFF8C00, 24'hFFD700,
          24'hADFF2F, 24'h008000, 24'h4B0082, 24'hFF69B4, 24'hFF1493,
          24'hFFA07A, 24'h1E90FF, 24'hFFE4C4, 24'hFFDAB9, 24'hF0E68C,
          24'hFFEFD5, 24'hFFF5EE, 24'hD2B48C, 24'hFFE4C4, 24'hADD8E6,
          24'hF08080, 24'hFFC0CB, 24'hFFB6C1, 24'hFFA07A, 24'hD2691E,
          24'hFFA500, 24'hFF7F27, 24'hFF4500, 24'hFF6347, 24'hFF6FCF,
          24'hFF1493, 24'h006400, 24'h483D8B, 24'h6A5ACD, 24'hFF8C68,
          24'hFFA07A, 24'hFFDAB9};
    return t[ci];
  endfunction

  function automatic int chan_of(input logic [23:0] c, input int k);
    return (c >> (16 - 8 * k)) & 8'hFF;
  endfunction

  function automatic longint fade_step(input int cur, input int tgt, input int len);
    longint mag, q;
    mag = longint'(cur > tgt ? cur - tgt : tgt - cur) << lcf_pkg::FRAC_BITS;
    q = (2 * mag + len) / (2 * longint'(len));
    return tgt >= cur ? q : -q;
  endfunction

  function automatic int to_byte(input longint a);
    longint q;
    if (a < 0) return 0;
    q = (a + (64'sd1 <<< (lcf_pkg::FRAC_BITS - 1))) >>> lcf_pkg::FRAC_BITS;
    return q > 255 ? 255 : int'(q);
  endfunction

  // Applies one word to the predictor and queues the frame, if any, that it causes.
  task automatic fade_predict(input word_t w);
    int n, len, d, st, v;
    int ch [3];
    frame_t f;
    longint hi, lo;
    hi = (64'sd1 <<< (lcf_pkg::FRAC_BITS + 9)) - 1;
    lo = -(64'sd1 <<< (lcf_pkg::FRAC_BITS + 9));
    case (w.op)
      lcf_pkg::OP_SET_RAW: mdl_tgt[w.led] = {w.r, w.g, w.b};
      lcf_pkg::OP_SET_PAL: if (w.ci < lcf_pkg::PAL_SIZE) mdl_tgt[w.led] = pal_rgb(w.ci);
      lcf_pkg::OP_ALL_PAL: if (w.ci < lcf_pkg::PAL_SIZE)
                    for (int i = 0; i < lcf_pkg::LED_COUNT; i++) mdl_tgt[i] = pal_rgb(w.ci);
      default: begin
        n = mdl_leds < 1 ? 1
          : (mdl_leds > lcf_pkg::LED_COUNT ? lcf_pkg::LED_COUNT : mdl_leds);
        if (mdl_left == 0) begin
          len = 0;
          for (int i = 0; i < n; i++)
            for (int k = 0; k < 3; k++) begin
              d = chan_of(mdl_cur[i], k) - chan_of(mdl_tgt[i], k);
              if (d < 0) d = -d;
              if (d > len) len = d;
            end
          if (len == 0) begin
            f = '{4'd0, 24'd0, lcf_pkg::ST_DONE, 1'b0, 1'b1};
            expected_frames.push_back(f);
            return;
          end
          mdl_left = len;
          for (int i = 0; i < n; i++)
            for (int k = 0; k < 3; k++) begin
              mdl_acc[i][k] = longint'(chan_of(mdl_cur[i], k)) << lcf_pkg::FRAC_BITS;
              mdl_stp[i][k] = fade_step(chan_of(mdl_cur[i], k),
                                        chan_of(mdl_tgt[i], k), len);
            end
        end
        for (int i = 0; i < n; i++) begin
          for (int k = 0; k < 3; k++) begin
            mdl_acc[i][k] = mdl_acc[i][k] + mdl_stp[i][k];
            if (mdl_acc[i][k] > hi) mdl_acc[i][k] = hi;
            if (mdl_acc[i][k] < lo) mdl_acc[i][k] = lo;
            ch[k] = to_byte(mdl_acc[i][k]);
          end
          mdl_cur[i] = {ch[0][7:0], ch[1][7:0], ch[2][7:0]};
        end
        if (w.abt) st = lcf_pkg::ST_ABORT;
        else begin
          mdl_left = (mdl_left - 1) & 8'hFF;
          st = mdl_left == 0 ? lcf_pkg::ST_DONE : lcf_pkg::ST_FADING;
        end
        for (int i = 0; i < n; i++) begin
          f.led = i[3:0];
          f.grb = {mdl_cur[i][15:8], mdl_cur[i][23:16], mdl_cur[i][7:0]};
          f.st  = st[1:0];
          f.fv  = 1'b1;
          f.lst = (i + 1 == n);
          expected_frames.push_back(f);
        end
        // On the final step every LED in use snaps to its target.
        if (st == lcf_pkg::ST_DONE)
          for (int i = 0; i < n; i++) mdl_cur[i] = mdl_tgt[i];
      end
    endcase
  endtask

  // The stall seen at the last rising edge decides whether the word went.
  logic in_stall_s = 1'b0;

  // Driver: changes inputs at the falling edge. A register write is taken
  // only once all frames are out and a quiet spell covers the tick latency.
  word_t head;
  int    drain_wait = 0;
  bit    word_taken;
  bit    cfg_go;
  bit    drive_now;
  always @(negedge clk) begin
    cfg_go = 1'b0;
    drive_now = 1'b0;
    word_taken = in_valid && !in_stall_s;
    if (!rst) begin
      if (!(in_valid && in_stall_s) && pending_words.size() > 0 && !hold_off) begin
        head = pending_words[0];
        if (head.is_cfg) begin
          if (!word_taken && expected_frames.size() == 0) begin
            drain_wait = drain_wait + 1;
            if (drain_wait > 500) begin
              cfg_go = 1'b1;
              cfg_write_data <= head.cfg_val;
              mdl_leds = head.cfg_val;
              void'(pending_words.pop_front());
              drain_wait = 0;
            end
          end else drain_wait = 0;
        end else if (quiet || $urandom_range(99) >= 17) begin
          void'(pending_words.pop_front());
          drive_now = 1'b1;
          op <= head.op; led_index <= head.led;
          red <= head.r; green <= head.g; blue <= head.b;
          color_index <= head.ci; abort_request <= head.abt;
          fade_predict(head);
        end
      end
      if (drive_now) in_valid <= 1'b1;
      else if (word_taken) in_valid <= 1'b0;
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 17);
    end
    cfg_write_enable <= cfg_go;
  end

  // Monitor: samples both channels at the rising edge.
  frame_t exp_f;
  always @(posedge clk) begin
    in_stall_s <= in_stall;
    if (!rst) begin
      if ((in_valid && !in_stall) || cfg_write_enable || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected frame word: led %0d grb %06h", out_led, grb_word);
          fail_count = fail_count + 1;
        end else begin
          exp_f = expected_frames.pop_front();
          if (out_led !== exp_f.led) begin
            $error("out_led: expected %0d actual %0d", exp_f.led, out_led);
            fail_count = fail_count + 1;
          end
          if (grb_word !== exp_f.grb) begin
            $error("grb_word: expected %06h actual %06h", exp_f.grb, grb_word);
            fail_count = fail_count + 1;
          end
          if (status !== exp_f.st) begin
            $error("status: expected %0d actual %0d", exp_f.st, status);
            fail_count = fail_count + 1;
          end
          if (frame_valid !== exp_f.fv) begin
            $error("frame_valid: expected %0b actual %0b", exp_f.fv, frame_valid);
            fail_count = fail_count + 1;
          end
          if (last !== exp_f.lst) begin
            $error("last: expected %0b actual %0b", exp_f.lst, last);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  // Watchdog: a long spell with no traffic at all means the block hung. The
  // drain wait before a register write stays far below this figure.
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("led_strip_color_fader_top regression: fail");
      $finish;
    end
  end

  function automatic word_t mk(input logic [1:0] o, input int l, input int rr,
                               input int gg, input int bb, input int c,
                               input bit a);
    word_t w;
    w.op = o; w.led = l[3:0]; w.r = rr[7:0]; w.g = gg[7:0]; w.b = bb[7:0];
    w.ci = c[5:0]; w.abt = a; w.is_cfg = 1'b0; w.cfg_val = '0;
    return w;
  endfunction

  function automatic word_t mk_cfg(input int v);
    word_t w;
    w = mk(lcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0);
    w.is_cfg = 1'b1; w.cfg_val = v[4:0];
    return w;
  endfunction

  function automatic word_t rand_word(input bit fade_heavy);
    int sel;
    sel = $urandom_range(99);
    if (fade_heavy && sel < 55)
      return mk(lcf_pkg::OP_TICK, $urandom, 0, 0, 0, $urandom, $urandom_range(9) == 0);
    if (sel < 75)
      return mk(lcf_pkg::OP_SET_RAW, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    if (sel < 92)
      return mk(lcf_pkg::OP_SET_PAL, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(63), $urandom);
    return mk(lcf_pkg::OP_ALL_PAL, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(63), $urandom);
  endfunction

  int cfg_plan [6] = '{1, 16, 0, 31, 7, 3};

  initial begin
    mdl_left = 0;
    mdl_leds = 16;
    for (int i = 0; i < lcf_pkg::LED_COUNT; i++) begin
      mdl_cur[i] = '0; mdl_tgt[i] = '0;
      for (int k = 0; k < 3; k++) begin
        mdl_acc[i][k] = 0; mdl_stp[i][k] = 0;
      end
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: idle tick, raw extremes, palette edges, a bad index,
    // a target change mid-fade, an aborted tick and a run of plain ticks.
    pending_words.push_back(mk(lcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0));
    pending_words.push_back(mk(lcf_pkg::OP_SET_RAW, 0, 255, 255, 255, 0, 1'b0));
    pending_words.push_back(mk(lcf_pkg::OP_SET_RAW, 15, 1, 0, 128, 63, 1'b1));
    pending_words.push_back(mk(lcf_pkg::OP_SET_PAL, 3, 0, 0, 0, 46, 1'b0));
    pending_words.push_back(mk(lcf_pkg::OP_SET_PAL, 4, 0, 0, 0, 47, 1'b0));
    pending_words.push_back(mk(lcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b1));
    pending_words.push_back(mk(lcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0));
    pending_words.push_back(mk(lcf_pkg::OP_SET_RAW, 1, 9, 200, 3, 0, 1'b0));
    pending_words.push_back(mk(lcf_pkg::OP_ALL_PAL, 0, 0, 0, 0, 63, 1'b0));
    for (int i = 0; i < 12; i++)
      pending_words.push_back(mk(lcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0));

    // Strips of several sizes, among them the register's extremes 0 and 31.
    foreach (cfg_plan[p]) begin
      pending_words.push_back(mk_cfg(cfg_plan[p]));
      pending_words.push_back(mk(lcf_pkg::OP_ALL_PAL, 0, 0, 0, 0,
                                 $urandom_range(46), 1'b0));
      for (int i = 0; i < 60; i++) pending_words.push_back(rand_word(1'b1));
    end
    pending_words.push_back(mk_cfg(16));

    // Run with no idling on either side for a while.
    wait (pending_words.size() < 200);
    quiet = 1'b1;
    wait (pending_words.size() < 140);
    quiet = 1'b0;

    // Hold the sender until every expected frame has drained once.
    wait (pending_words.size() < 100);
    hold_off = 1'b1;
    wait (expected_frames.size() == 0);
    hold_off = 1'b0;

    wait (pending_words.size() == 0);
    wait (expected_frames.size() == 0);
    repeat (600) @(posedge clk);
    if (fail_count == 0 && expected_frames.size() == 0)
      $display("led_strip_color_fader_top regression: pass");
    else
      $display("led_strip_color_fader_top regression: fail");
    $finish;
  end
endmodule
